### src/csb_pkg.sv
// shared constants, types and helpers for the clipped sprite blit engine
package csb_pkg;

	// build-time limits
	localparam int PIXEL_BITS    = 8;
	localparam int MAX_FRAME_DIM = 1024;
	localparam int BUFFERS       = 8;

	// fixed field widths
	localparam int DIM_W    = 11;
	localparam int HOT_W    = 10;
	localparam int POS_W    = 16;
	localparam int COORD_W  = 13;
	localparam int STRIDE_W = 14;
	localparam int COUNT_W  = 9;
	localparam int ADDR_W   = 25;
	localparam int BUF_W    = 3;
	localparam int PIX_W    = 8;
	localparam int FIDX_W   = 8;
	localparam int ORG_W    = POS_W + 1;
	localparam int SCR_W    = ORG_W + 1;
	localparam int PROD_W   = COORD_W + STRIDE_W;
	localparam int CFG_W    = STRIDE_W;

	// a frame dimension never exceeds what the 11-bit field can carry
	localparam int MAX_DIM_EFF = (MAX_FRAME_DIM > 2047) ? 2047 : MAX_FRAME_DIM;
	localparam int COL_W       = $clog2(MAX_DIM_EFF);

	// pixel bits kept from the source value
	localparam logic [PIX_W-1:0] PIX_MASK =
		(PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << PIXEL_BITS) - 1);

	// stream packing
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 40;

	// request queue between front and back, depth a power of two
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// input kinds
	localparam logic OP_START = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_ROW_STRIDE    = 2'd2,
		CFG_FRAME_COUNT   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0]  screen_width;
		logic [COORD_W-1:0]  screen_height;
		logic [STRIDE_W-1:0] row_stride;
		logic [COUNT_W-1:0]  frame_count;
	} cfg_t;

	// one clipped write waiting for its address
	typedef struct packed {
		logic [BUF_W-1:0]   buf_id;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [PIX_W-1:0]   pix;
	} wr_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic pop;
		logic s1_valid;
	} back_stat_t;

	// saturate a frame dimension
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		return (int'(d) > MAX_DIM_EFF) ? DIM_W'(MAX_DIM_EFF) : d;
	endfunction

endpackage

### src/csb_front.sv
// front end: takes start and pixel requests, walks the frame and clips each pixel
module csb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// fields from bit 0: pos_x, pos_y, hot_x, hot_y, frame_width, frame_height,
	// transparent, buffer_index, frame_index, pixel, zero fill
	input  logic [csb_pkg::IN_TDATA_W-1:0]  s_tdata,
	// op
	input  logic                            s_tuser,
	input  csb_pkg::cfg_t                   cfg,
	input  csb_pkg::q_stat_t                q_stat,
	output logic                            push,
	output csb_pkg::wr_cmd_t                push_cmd
);
	import csb_pkg::*;

	logic               active_q, blit_valid_q, mode_q;
	logic [ORG_W-1:0]   origin_x_q, origin_y_q;
	logic [COL_W-1:0]   column_q, row_q;
	logic [DIM_W-1:0]   width_q, height_q;
	logic [BUF_W-1:0]   buf_q;

	logic [POS_W-1:0]   pos_x, pos_y;
	logic [HOT_W-1:0]   hot_x, hot_y;
	logic [DIM_W-1:0]   fw, fh, fw_c, fh_c;
	logic               transp;
	logic [BUF_W-1:0]   bufi;
	logic [FIDX_W-1:0]  fidx;
	logic [PIX_W-1:0]   pix;

	logic               accept, start, step;
	logic [SCR_W-1:0]   sx_ext, sy_ext;
	logic               on_x, on_y, emit;
	logic [DIM_W-1:0]   col_nx, row_nx;

	// unpack the request
	assign pos_x  = s_tdata[15:0];
	assign pos_y  = s_tdata[31:16];
	assign hot_x  = s_tdata[41:32];
	assign hot_y  = s_tdata[51:42];
	assign fw     = s_tdata[62:52];
	assign fh     = s_tdata[73:63];
	assign transp = s_tdata[74];
	assign bufi   = s_tdata[77:75];
	assign fidx   = s_tdata[85:78];
	assign pix    = s_tdata[93:86] & PIX_MASK;

	assign fw_c = clamp_dim(fw);
	assign fh_c = clamp_dim(fh);

	// stall only on a full queue
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign start    = accept && (s_tuser == OP_START);
	assign step     = accept && (s_tuser == OP_PIXEL) && active_q;

	// screen point of the current pixel and the four-side clip
	assign sx_ext = {origin_x_q[ORG_W-1], origin_x_q} + SCR_W'(column_q);
	assign sy_ext = {origin_y_q[ORG_W-1], origin_y_q} + SCR_W'(row_q);
	assign on_x   = !sx_ext[SCR_W-1] && (sx_ext[SCR_W-2:0] < ORG_W'(cfg.screen_width));
	assign on_y   = !sy_ext[SCR_W-1] && (sy_ext[SCR_W-2:0] < ORG_W'(cfg.screen_height));
	assign emit   = blit_valid_q && on_x && on_y && (!mode_q || (pix != '0));

	assign push            = step && emit;
	assign push_cmd.buf_id = buf_q;
	assign push_cmd.sx     = sx_ext[COORD_W-1:0];
	assign push_cmd.sy     = sy_ext[COORD_W-1:0];
	assign push_cmd.pix    = pix;

	// raster counters
	assign col_nx = DIM_W'(column_q) + 1'b1;
	assign row_nx = DIM_W'(row_q) + 1'b1;

	// blit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			blit_valid_q <= 1'b0;
			mode_q       <= 1'b0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			column_q     <= '0;
			row_q        <= '0;
			width_q      <= '0;
			height_q     <= '0;
			buf_q        <= '0;
		end else if (start) begin
			origin_x_q   <= {pos_x[POS_W-1], pos_x} - ORG_W'(hot_x);
			origin_y_q   <= {pos_y[POS_W-1], pos_y} - ORG_W'(hot_y);
			width_q      <= fw_c;
			height_q     <= fh_c;
			mode_q       <= transp;
			buf_q        <= bufi;
			blit_valid_q <= ({1'b0, fidx} < cfg.frame_count) && (int'(bufi) < BUFFERS);
			column_q     <= '0;
			row_q        <= '0;
			active_q     <= (fw_c != '0) && (fh_c != '0);
		end else if (step) begin
			if (col_nx >= width_q) begin
				column_q <= '0;
				if (row_nx >= height_q) begin
					row_q    <= '0;
					active_q <= 1'b0;
				end else begin
					row_q <= row_nx[COL_W-1:0];
				end
			end else begin
				column_q <= col_nx[COL_W-1:0];
			end
		end
	end

endmodule

### src/csb_queue.sv
// small request queue that decouples the clipping front from the address back end
module csb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csb_pkg::wr_cmd_t  push_cmd,
	input  logic              pop,
	output csb_pkg::wr_cmd_t  head,
	output csb_pkg::q_stat_t  q_stat
);
	import csb_pkg::*;

	wr_cmd_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/csb_back.sv
// back end: forms row*stride+column and holds the write until the sink takes it
module csb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [csb_pkg::STRIDE_W-1:0]  row_stride,
	input  csb_pkg::wr_cmd_t              head,
	input  csb_pkg::q_stat_t              q_stat,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [csb_pkg::BUF_W-1:0]     buffer_out,
	output logic [csb_pkg::ADDR_W-1:0]    address,
	output logic [csb_pkg::PIX_W-1:0]     data,
	output csb_pkg::back_stat_t           bk_stat
);
	import csb_pkg::*;

	logic                valid_s1, valid_s2;
	wr_cmd_t             cmd_s1;
	logic [BUF_W-1:0]    buf_s2;
	logic [ADDR_W-1:0]   addr_s2;
	logic [PIX_W-1:0]    data_s2;

	logic                take_s2, take_s1;
	logic [PROD_W-1:0]   prod, addr_full;

	// stage handshakes
	assign take_s2 = !valid_s2 || m_tready;
	assign take_s1 = !valid_s1 || take_s2;
	assign bk_stat.pop      = !q_stat.empty && take_s1;
	assign bk_stat.s1_valid = valid_s1;

	// address arithmetic
	assign prod      = PROD_W'(cmd_s1.sy) * PROD_W'(row_stride);
	assign addr_full = prod + PROD_W'(cmd_s1.sx);

	// stage 1: request popped from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (bk_stat.pop) begin
			cmd_s1 <= head;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && valid_s1) begin
			buf_s2  <= cmd_s1.buf_id;
			addr_s2 <= addr_full[ADDR_W-1:0];
			data_s2 <= cmd_s1.pix;
		end
	end

	assign m_tvalid   = valid_s2;
	assign buffer_out = buf_s2;
	assign address    = addr_s2;
	assign data       = data_s2;

endmodule

### src/clipped_sprite_blit.sv
// top level of the clipped sprite blit engine with color key
// throughput: one request per cycle, start or pixel, while the request queue is not full
// path: a written pixel reaches m_tvalid through a queue slot, then the stage one register
//   that feeds the multiply, then the output register; back-pressure can hold it at each
// reset: registers return to 320/200/320/0, engine idle, queue and pipeline empty
module clipped_sprite_blit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// fields from bit 0: pos_x, pos_y, hot_x, hot_y, frame_width, frame_height,
	// transparent, buffer_index, frame_index, pixel, zero fill
	input  logic [csb_pkg::IN_TDATA_W-1:0]   s_tdata,
	// op
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// fields from bit 0: buffer_out, address, data, zero fill
	output logic [csb_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [csb_pkg::CFG_W-1:0]        cfg_data
);
	import csb_pkg::*;

	cfg_t              cfg_q;
	q_stat_t           q_stat;
	back_stat_t        bk_stat;
	logic              push;
	wr_cmd_t           push_cmd, head;
	logic [BUF_W-1:0]  buffer_out;
	logic [ADDR_W-1:0] address;
	logic [PIX_W-1:0]  data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= COORD_W'(320);
			cfg_q.screen_height <= COORD_W'(200);
			cfg_q.row_stride    <= STRIDE_W'(320);
			cfg_q.frame_count   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[COORD_W-1:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[COORD_W-1:0];
				CFG_ROW_STRIDE:    cfg_q.row_stride    <= cfg_data[STRIDE_W-1:0];
				CFG_FRAME_COUNT:   cfg_q.frame_count   <= cfg_data[COUNT_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	csb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	csb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (bk_stat.pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	csb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_stride (cfg_q.row_stride),
		.head       (head),
		.q_stat     (q_stat),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.buffer_out (buffer_out),
		.address    (address),
		.data       (data),
		.bk_stat    (bk_stat)
	);

	// pack the write request
	assign m_tdata = {(OUT_TDATA_W - BUF_W - ADDR_W - PIX_W)'(0), data, address, buffer_out};

	// checks
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("front pushed into a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> !q_stat.empty)
		else $error("back end popped an empty queue");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(bk_stat.s1_valid))
		else $error("write request appeared without a stage one entry");

endmodule

### sim/blit_write_checker.sv
// checker for the clipped sprite blit: predicts pixel writes from requests and compares them
module blit_write_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [csb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [csb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [csb_pkg::CFG_W-1:0]       cfg_data,
	output int                              fails,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import csb_pkg::*;

	// request layout, top field first
	typedef struct packed {
		logic [1:0]        fill;
		logic [PIX_W-1:0]  pix;
		logic [FIDX_W-1:0] frame_idx;
		logic [BUF_W-1:0]  buf_sel;
		logic              keyed;
		logic [DIM_W-1:0]  height;
		logic [DIM_W-1:0]  width;
		logic [HOT_W-1:0]  hot_y;
		logic [HOT_W-1:0]  hot_x;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_x;
	} blit_req_t;

	typedef struct {
		logic [BUF_W-1:0]  dest;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pix;
	} pixel_write_t;

	// screen registers
	logic [COORD_W-1:0]  scr_w, scr_h;
	logic [STRIDE_W-1:0] stride;
	logic [COUNT_W-1:0]  n_frames;

	// blit in progress
	logic                    busy, frame_ok, keyed_l;
	logic signed [ORG_W-1:0] org_x, org_y;
	logic [COL_W-1:0]        col, row;
	logic [DIM_W-1:0]        width_l, height_l;
	logic [BUF_W-1:0]        dest_l;

	pixel_write_t writes_due[$];

	always @(posedge clk or negedge arst_n) begin
		blit_req_t    req;
		pixel_write_t want, got;
		int           sx, sy, ncol, nrow;
		if (!arst_n) begin
			scr_w    <= COORD_W'(320);
			scr_h    <= COORD_W'(200);
			stride   <= STRIDE_W'(320);
			n_frames <= '0;
			busy     <= 1'b0;
			frame_ok <= 1'b0;
			keyed_l  <= 1'b0;
			org_x    <= '0;
			org_y    <= '0;
			col      <= '0;
			row      <= '0;
			width_l  <= '0;
			height_l <= '0;
			dest_l   <= '0;
			writes_due.delete();
			fails    <= 0;
			pending  <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SCREEN_WIDTH:  scr_w    <= cfg_data[COORD_W-1:0];
					CFG_SCREEN_HEIGHT: scr_h    <= cfg_data[COORD_W-1:0];
					CFG_ROW_STRIDE:    stride   <= cfg_data[STRIDE_W-1:0];
					CFG_FRAME_COUNT:   n_frames <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end

			// accepted request
			if (s_tvalid && s_tready) begin
				req = s_tdata;
				if (s_tuser == OP_START) begin
					org_x    <= ORG_W'(int'(signed'(req.pos_x)) - int'(req.hot_x));
					org_y    <= ORG_W'(int'(signed'(req.pos_y)) - int'(req.hot_y));
					width_l  <= (req.width > MAX_FRAME_DIM) ? DIM_W'(MAX_FRAME_DIM) : req.width;
					height_l <= (req.height > MAX_FRAME_DIM) ? DIM_W'(MAX_FRAME_DIM) : req.height;
					keyed_l  <= req.keyed;
					dest_l   <= req.buf_sel;
					frame_ok <= (req.frame_idx < n_frames) && (int'(req.buf_sel) < BUFFERS);
					col      <= '0;
					row      <= '0;
					busy     <= (req.width != 0) && (req.height != 0);
				end else if (busy) begin
					sx = int'(org_x) + int'(col);
					sy = int'(org_y) + int'(row);
					// clip on all four sides, then color key
					if (frame_ok && sx >= 0 && sy >= 0 && sx < int'(scr_w) && sy < int'(scr_h)
							&& (!keyed_l || req.pix != 0)) begin
						want.dest = dest_l;
						want.addr = ADDR_W'(sy * int'(stride) + sx);
						want.pix  = req.pix;
						writes_due.push_back(want);
					end
					// raster walk, column fastest
					ncol = int'(col) + 1;
					if (ncol >= int'(width_l)) begin
						col  <= '0;
						nrow = int'(row) + 1;
						if (nrow >= int'(height_l)) begin
							row  <= '0;
							busy <= 1'b0;
						end else begin
							row <= COL_W'(nrow);
						end
					end else begin
						col <= COL_W'(ncol);
					end
				end
			end

			// accepted write
			if (m_tvalid && m_tready) begin
				got.dest = m_tdata[BUF_W-1:0];
				got.addr = m_tdata[BUF_W+ADDR_W-1:BUF_W];
				got.pix  = m_tdata[BUF_W+ADDR_W+PIX_W-1:BUF_W+ADDR_W];
				if (writes_due.size() == 0) begin
					if (fails < 10)
						$display("%0t: unexpected write buf %0d addr %h data %h",
							$realtime, got.dest, got.addr, got.pix);
					fails <= fails + 1;
				end else begin
					want = writes_due.pop_front();
					if (want.dest != got.dest || want.addr != got.addr || want.pix != got.pix) begin
						if (fails < 10)
							$display("%0t: bad write, expected buf %0d addr %h data %h, got buf %0d addr %h data %h",
								$realtime, want.dest, want.addr, want.pix,
								got.dest, got.addr, got.pix);
						fails <= fails + 1;
					end
				end
			end

			pending <= writes_due.size();
		end
	end

endmodule

### sim/clipped_sprite_blit_tb.sv
// testbench top for the clipped sprite blit: drives blits and screen settings, gives the verdict
module clipped_sprite_blit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import csb_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [1:0]             cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	int fails;
	int pending;
	bit calm;

	// current screen settings, used to aim blits near the edges
	int cur_sw, cur_sh, cur_fc;

	clipped_sprite_blit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	blit_write_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard limit on the run
	initial begin
		#8000000;
		$display("Mismatches found");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// write side back-pressure
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				if (!calm && $urandom_range(0, 99) < 25)
					hold = idle_span();
			end
		end
	end

	// present one request and hold it until taken
	task automatic offer_request(input logic op, input logic [IN_TDATA_W-1:0] d);
		int gap;
		gap = calm ? 0 : idle_span();
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic issue_blit(input int px, input int py, input int hx, input int hy,
			input int fw, input int fh, input int tr, input int bi, input int fi);
		logic [PIX_W-1:0] junk;
		junk = $urandom_range(0, 255);
		offer_request(OP_START, {2'b00, junk, fi[7:0], bi[2:0], tr[0], fh[10:0], fw[10:0],
			hy[9:0], hx[9:0], py[15:0], px[15:0]});
	endtask

	// pixel request; the geometry bits carry noise
	task automatic feed_pixel(input int pix);
		logic [85:0] junk;
		junk = 86'({$urandom, $urandom, $urandom});
		offer_request(OP_PIXEL, {2'b00, pix[7:0], junk});
	endtask

	function automatic int rand_pixel();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
	endfunction

	// stop sending and let every write come out
	task automatic drain_writes();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_W'(v);
	endtask

	task automatic program_screen(input int sw, input int sh, input int st, input int fc);
		write_reg(CFG_SCREEN_WIDTH, sw);
		write_reg(CFG_SCREEN_HEIGHT, sh);
		write_reg(CFG_ROW_STRIDE, st);
		write_reg(CFG_FRAME_COUNT, fc);
		@(negedge clk);
		cfg_we = 1'b0;
		cur_sw = sw;
		cur_sh = sh;
		cur_fc = fc;
	endtask

	// small blits placed around the screen edges, some cut short or noisy
	task automatic random_blits(input int n);
		int counted, r, fw, fh, hx, hy, px, py, fi, npix;
		counted = 0;
		while (counted < n) begin
			calm = ($urandom_range(0, 4) == 0);
			r  = $urandom_range(0, 99);
			fw = (r < 4) ? 0 : $urandom_range(1, 12);
			fh = (r >= 4 && r < 8) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 6) == 0) begin
				hx = $urandom_range(0, 1023);
				hy = $urandom_range(0, 1023);
			end else begin
				hx = $urandom_range(0, 15);
				hy = $urandom_range(0, 15);
			end
			px = int'($urandom_range(0, cur_sw + fw + 4)) - fw - 2 + hx;
			py = int'($urandom_range(0, cur_sh + fh + 4)) - fh - 2 + hy;
			if ($urandom_range(0, 9) == 0) begin
				px = $urandom_range(0, 65535);
				py = $urandom_range(0, 65535);
			end
			if (cur_fc != 0 && $urandom_range(0, 4) != 0)
				fi = $urandom_range(0, cur_fc - 1);
			else
				fi = $urandom_range(0, 255);
			issue_blit(px, py, hx, hy, fw, fh, $urandom_range(0, 1), $urandom_range(0, 7), fi);
			npix = fw * fh;
			// cut short so the next start lands mid-frame
			if ($urandom_range(0, 6) == 0)
				npix = $urandom_range(0, npix);
			repeat (npix) feed_pixel(rand_pixel());
			counted += 1 + npix;
			// stray pixels after the frame
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3)) feed_pixel(rand_pixel());
		end
		calm = 1'b0;
	endtask

	initial begin
		int guard;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_START;
		cfg_we    = 1'b0;
		cfg_index = CFG_SCREEN_WIDTH;
		cfg_data  = '0;
		calm      = 1'b0;
		cur_sw    = 320;
		cur_sh    = 200;
		cur_fc    = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: no frame is valid yet
		random_blits(20);
		drain_writes();

		// directed blits on a 320x200 screen with eight frames
		program_screen(320, 200, 320, 8);
		feed_pixel(8'h5a);
		issue_blit(0, 0, 0, 0, 2, 2, 0, 7, 0);
		feed_pixel(8'hff);
		feed_pixel(8'h00);
		feed_pixel(8'haa);
		feed_pixel(8'h55);
		// color key, clipped on the right and bottom
		issue_blit(319, 199, 1, 1, 3, 3, 1, 0, 7);
		feed_pixel(8'h01);
		feed_pixel(8'h00);
		feed_pixel(8'h02);
		feed_pixel(8'h03);
		feed_pixel(8'h00);
		feed_pixel(8'h04);
		feed_pixel(8'h05);
		feed_pixel(8'h06);
		feed_pixel(8'h07);
		// frame index equal to the count
		issue_blit(10, 10, 0, 0, 1, 2, 0, 1, 8);
		feed_pixel(8'h11);
		feed_pixel(8'h22);
		// extreme position and hotspot, oversized frame, then restarted mid-frame
		issue_blit(-32768, 32767, 1023, 1023, 2047, 2047, 0, 2, 3);
		feed_pixel(8'h33);
		feed_pixel(8'h44);
		// zero width ends the blit at once
		issue_blit(0, 0, 0, 0, 0, 5, 0, 4, 1);
		feed_pixel(8'h66);
		// top row clipped, lower rows still drawn
		issue_blit(5, -1, 0, 0, 1, 3, 0, 6, 2);
		feed_pixel(8'h77);
		feed_pixel(8'h88);
		feed_pixel(8'h99);

		// random phases over several screen settings
		for (int p = 0; p < 7; p++) begin
			drain_writes();
			case (p)
				0: program_screen(1, 1, 1, 1);
				1: program_screen(4096, 4096, 8192, 256);
				2: program_screen(0, 200, 8192, 256);
				3: program_screen(64, 0, 64, 255);
				default: program_screen($urandom_range(1, 400), $urandom_range(1, 300),
					$urandom_range(1, 8192), $urandom_range(0, 256));
			endcase
			random_blits(115);
		end

		// wait for the last writes
		@(negedge clk);
		s_tvalid = 1'b0;
		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
